@@ sv/assert_macros.svh @@
// assertion macros used by the noise generator controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PN2F_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PN2F_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PN2F_ASSERT(lbl, clk, rstn, prop, msg)
`define PN2F_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ sv/pn2f_pkg.sv @@
// shared types, constants and the arithmetic schedule of the noise generator
package pn2f_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = 8;

  localparam logic [3:0]  OCT_RST  = 4'd4;
  localparam logic [15:0] PERS_RST = 16'h8000;
  localparam logic [16:0] AMP_ONE  = 17'h10000;

  localparam logic [4:0] LOOK_LAST  = 5'd10;
  localparam logic [4:0] ARITH_LAST = 5'd17;
  localparam logic [4:0] DIV_LAST   = 5'd15;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  typedef enum logic {
    CFG_OCTAVES = 1'b0,
    CFG_PERSIST = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ARITH,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TX2,
    OP_TY2,
    OP_TX3,
    OP_TY3,
    OP_TX4,
    OP_TY4,
    OP_TX5,
    OP_TY5,
    OP_FADE,
    OP_LLO,
    OP_LHI,
    OP_LY,
    OP_ACC,
    OP_AMP
  } arith_op_e;

  typedef struct packed {
    logic      ld_eval;
    logic      tbl_wr;
    logic      look_en;
    logic [3:0] look_idx;
    arith_op_e op;
    logic      next_oct;
    logic      div_init;
    logic      div_step;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic last_oct;
    logic out_free;
  } sts_t;

  // per-octave arithmetic schedule, at most one shared multiplier issue per step
  function automatic arith_op_e arith_op(input logic [4:0] step);
    arith_op_e op;
    unique case (step)
      5'd0:    op = OP_TX2;
      5'd1:    op = OP_TY2;
      5'd2:    op = OP_TX3;
      5'd3:    op = OP_TY3;
      5'd4:    op = OP_TX4;
      5'd5:    op = OP_TY4;
      5'd6:    op = OP_TX5;
      5'd7:    op = OP_TY5;
      5'd9:    op = OP_FADE;
      5'd10:   op = OP_LLO;
      5'd11:   op = OP_LHI;
      5'd13:   op = OP_LY;
      5'd15:   op = OP_ACC;
      5'd16:   op = OP_AMP;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ sv/pn2f_ram.sv @@
// generic single-write, single-read memory with registered read data
module pn2f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/pn2f_dp.sv @@
// datapath: permutation table, shared multiplier, fade, gradients, accumulation, divider
module pn2f_dp #(
  parameter int MAX_OCTAVES = pn2f_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = pn2f_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pn2f_pkg::cmd_t         cmd_i,
  output pn2f_pkg::sts_t         sts_o,
  input  logic                   cfg_we_i,
  input  pn2f_pkg::cfg_idx_e     cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [7:0]             table_index_i,
  input  logic [7:0]             table_value_i,
  input  logic [FRAC_BITS+7:0]   x_coord_i,
  input  logic [FRAC_BITS+7:0]   y_coord_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [15:0]            height_o
);
  import pn2f_pkg::*;

  localparam int CW = FRAC_BITS + 8;
  localparam int GW = FRAC_BITS + 3;
  localparam int MW = (FRAC_BITS + 4 > 18) ? FRAC_BITS + 4 : 18;
  localparam int PW = 2 * MW;
  localparam int FW = FRAC_BITS + 6;
  localparam int NW = $clog2(MAX_OCTAVES + 1);
  localparam int WW = 17 + NW;
  localparam int TW = FRAC_BITS + 20 + NW;
  localparam int DW = WW + FRAC_BITS;
  localparam logic signed [GW-1:0] ONE_G = GW'(1 << FRAC_BITS);
  localparam logic [4:0] MAX_E = 5'(MAX_OCTAVES);

  // configuration
  logic [3:0]  oct_cnt_q;
  logic [15:0] pers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q <= OCT_RST;
      pers_q    <= PERS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OCTAVES: oct_cnt_q <= cfg_data_i[3:0];
        CFG_PERSIST: pers_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // permutation table, unwritten entries read as their own index
  logic [TBL_DEPTH-1:0] vld_q;
  logic [TBL_AW-1:0]    rd_addr, rd_addr_q, ram_q, rd_data;
  logic                 rd_vld_q;

  pn2f_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tbl_wr),
    .waddr_i (table_index_i),
    .wdata_i (table_value_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.tbl_wr) begin
      vld_q[table_index_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    rd_vld_q  <= vld_q[rd_addr];
  end

  assign rd_data = rd_vld_q ? ram_q : rd_addr_q;

  // point and per-octave state
  logic [CW-1:0]    x_q, y_q;
  logic [NW-1:0]    oct_idx_q;
  logic [7:0]       lk_q [10];
  logic [7:0]       cx, cy, ha, hb;
  logic [FRAC_BITS-1:0] fx, fy;

  assign cx = x_q[CW-1:FRAC_BITS];
  assign cy = y_q[CW-1:FRAC_BITS];
  assign fx = x_q[FRAC_BITS-1:0];
  assign fy = y_q[FRAC_BITS-1:0];
  assign ha = lk_q[0] + cy;
  assign hb = lk_q[1] + cy;

  always_comb begin
    case (cmd_i.look_idx)
      4'd0:    rd_addr = cx;
      4'd1:    rd_addr = cx + 8'd1;
      4'd2:    rd_addr = ha;
      4'd3:    rd_addr = ha + 8'd1;
      4'd4:    rd_addr = hb;
      4'd5:    rd_addr = hb + 8'd1;
      4'd6:    rd_addr = lk_q[2];
      4'd7:    rd_addr = lk_q[3];
      4'd8:    rd_addr = lk_q[4];
      4'd9:    rd_addr = lk_q[5];
      default: rd_addr = cx;
    endcase
  end

  function automatic logic [FRAC_BITS:0] fade(input logic [FRAC_BITS-1:0] t3,
                                              input logic [FRAC_BITS-1:0] t4,
                                              input logic [FRAC_BITS-1:0] t5);
    logic signed [FW-1:0] e3, e4, e5, r;
    e3 = FW'(t3);
    e4 = FW'(t4);
    e5 = FW'(t5);
    r  = (e3 <<< 3) + (e3 <<< 1) - ((e4 <<< 4) - e4) + (e5 <<< 2) + (e5 <<< 1);
    if (r < 0) begin
      return '0;
    end else if (r > FW'(1 << FRAC_BITS)) begin
      return (FRAC_BITS+1)'(1 << FRAC_BITS);
    end
    return r[FRAC_BITS:0];
  endfunction

  function automatic logic signed [GW-1:0] grad(input logic [7:0] hash,
                                                input logic signed [GW-1:0] dx,
                                                input logic signed [GW-1:0] dy);
    logic [3:0] h;
    logic signed [GW-1:0] u, v;
    h = hash[3:0];
    u = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) begin
      v = dy;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = dx;
    end else begin
      v = '0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic signed [GW-1:0] dx0, dx1, dy0, dy1;
  assign dx0 = GW'(fx);
  assign dy0 = GW'(fy);
  assign dx1 = dx0 - ONE_G;
  assign dy1 = dy0 - ONE_G;

  // shared multiplier
  logic [FRAC_BITS-1:0] tx2_q, tx3_q, tx4_q, tx5_q, ty2_q, ty3_q, ty4_q, ty5_q;
  logic [FRAC_BITS:0]   u_q, v_q;
  logic signed [GW-1:0] ga_q, gb_q, gc_q, gd_q, lo_q, hi_q, oct_q, res;
  logic signed [GW:0]   d_lo, d_hi, d_y;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_q, prod_sh;
  arith_op_e            last_op_q;
  logic signed [TW-1:0] total_q;
  logic [16:0]          amp_q;
  logic [WW-1:0]        wt_q;

  assign d_lo = (GW+1)'(gb_q) - (GW+1)'(ga_q);
  assign d_hi = (GW+1)'(gd_q) - (GW+1)'(gc_q);
  assign d_y  = (GW+1)'(hi_q) - (GW+1)'(lo_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_TX2: begin mul_a = MW'(fx);    mul_b = MW'(fx); end
      OP_TY2: begin mul_a = MW'(fy);    mul_b = MW'(fy); end
      OP_TX3: begin mul_a = MW'(tx2_q); mul_b = MW'(fx); end
      OP_TY3: begin mul_a = MW'(ty2_q); mul_b = MW'(fy); end
      OP_TX4: begin mul_a = MW'(tx3_q); mul_b = MW'(fx); end
      OP_TY4: begin mul_a = MW'(ty3_q); mul_b = MW'(fy); end
      OP_TX5: begin mul_a = MW'(tx4_q); mul_b = MW'(fx); end
      OP_TY5: begin mul_a = MW'(ty4_q); mul_b = MW'(fy); end
      OP_LLO: begin mul_a = MW'(u_q);   mul_b = MW'(d_lo); end
      OP_LHI: begin mul_a = MW'(u_q);   mul_b = MW'(d_hi); end
      OP_LY:  begin mul_a = MW'(v_q);   mul_b = MW'(d_y); end
      OP_ACC: begin mul_a = MW'(oct_q); mul_b = MW'(amp_q); end
      OP_AMP: begin mul_a = MW'(amp_q); mul_b = MW'(pers_q); end
      default: ;
    endcase
  end

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign res     = lo_q + GW'(prod_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_op_q <= OP_NOP;
    end else begin
      last_op_q <= cmd_i.op;
    end
  end

  // divider state
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_q, rem2;
  logic          ge, zero_q, big_q;
  logic [15:0]   quot_q, height_q;

  assign dvs  = {wt_q, {FRAC_BITS{1'b0}}};
  assign rem2 = {rem_q[DW-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.ld_eval) begin
      x_q       <= x_coord_i;
      y_q       <= y_coord_i;
      oct_idx_q <= '0;
      total_q   <= '0;
      amp_q     <= AMP_ONE;
      wt_q      <= '0;
    end
    if (cmd_i.next_oct) begin
      x_q       <= {x_q[CW-2:0], 1'b0};
      y_q       <= {y_q[CW-2:0], 1'b0};
      oct_idx_q <= oct_idx_q + NW'(1);
    end
    if (cmd_i.look_en && cmd_i.look_idx != 4'd0) begin
      lk_q[cmd_i.look_idx - 4'd1] <= rd_data;
    end
    // issue-time actions
    case (cmd_i.op)
      OP_FADE: begin
        u_q  <= fade(tx3_q, tx4_q, tx5_q);
        v_q  <= fade(ty3_q, ty4_q, ty5_q);
        ga_q <= grad(lk_q[6], dx0, dy0);
        gb_q <= grad(lk_q[8], dx1, dy0);
        gc_q <= grad(lk_q[7], dx0, dy1);
        gd_q <= grad(lk_q[9], dx1, dy1);
      end
      OP_ACC:  wt_q <= wt_q + WW'(amp_q);
      default: ;
    endcase
    // product write-back, in the cycle after issue
    case (last_op_q)
      OP_TX2:  tx2_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TY2:  ty2_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TX3:  tx3_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TY3:  ty3_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TX4:  tx4_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TY4:  ty4_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TX5:  tx5_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_TY5:  ty5_q <= prod_q[2*FRAC_BITS-1:FRAC_BITS];
      OP_LLO:  lo_q  <= ga_q + GW'(prod_sh);
      OP_LHI:  hi_q  <= gc_q + GW'(prod_sh);
      OP_LY:   oct_q <= (res + ONE_G) >>> 1;
      OP_ACC:  total_q <= total_q + TW'(prod_q);
      OP_AMP:  amp_q <= prod_q[32:16];
      default: ;
    endcase
    if (cmd_i.div_init) begin
      zero_q <= total_q[TW-1] || (total_q == '0);
      big_q  <= $unsigned(total_q) >= TW'(dvs);
      rem_q  <= total_q[DW:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? rem2 - {1'b0, dvs} : rem2;
      quot_q <= {quot_q[14:0], ge};
    end
    if (cmd_i.out_load) begin
      height_q <= zero_q ? 16'h0000 : (big_q ? 16'hFFFF : quot_q);
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;

  // octave count limited to 1..MAX_OCTAVES
  logic [4:0] oc_e, n_e;

  always_comb begin
    oc_e = {1'b0, oct_cnt_q};
    if (oc_e == 5'd0) begin
      n_e = 5'd1;
    end else if (oc_e > MAX_E) begin
      n_e = MAX_E;
    end else begin
      n_e = oc_e;
    end
  end

  assign sts_o.last_oct = (5'(oct_idx_q) == n_e - 5'd1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

@@ sv/pn2f_ctrl.sv @@
// controller: sequences lookups, arithmetic steps, division and result hand-off
`include "assert_macros.svh"
module pn2f_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           opcode_i,
  output logic           in_stall_o,
  input  pn2f_pkg::sts_t sts_i,
  output pn2f_pkg::cmd_t cmd_o
);
  import pn2f_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && opcode_i == OPC_EVAL) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cnt_q == LOOK_LAST) begin
          state_d = ST_ARITH;
          cnt_d   = '0;
        end
      end
      ST_ARITH: begin
        if (cnt_q == ARITH_LAST) begin
          state_d = sts_i.last_oct ? ST_DIV : ST_LOOK;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_OUT;
          cnt_d   = '0;
        end
      end
      ST_OUT: begin
        cnt_d = '0;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.op = OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_eval = (opcode_i == OPC_EVAL);
          cmd_o.tbl_wr  = (opcode_i == OPC_WRITE);
        end
      end
      ST_LOOK: begin
        cmd_o.look_en  = 1'b1;
        cmd_o.look_idx = cnt_q[3:0];
      end
      ST_ARITH: begin
        cmd_o.op = arith_op(cnt_q);
        if (cnt_q == ARITH_LAST) begin
          cmd_o.next_oct = 1'b1;
          cmd_o.div_init = sts_i.last_oct;
        end
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  `PN2F_ASSERT(a_eval_starts, clk_i, rst_ni, (in_valid_i && !in_stall_o && opcode_i == OPC_EVAL) |=> (state_q == ST_LOOK && cnt_q == 5'd0), "eval request did not start lookups")
  `PN2F_ASSERT(a_look_to_arith, clk_i, rst_ni, (state_q == ST_LOOK && cnt_q == LOOK_LAST) |=> (state_q == ST_ARITH), "lookups not followed by arithmetic")
  `PN2F_ASSERT(a_div_to_out, clk_i, rst_ni, (state_q == ST_DIV && cnt_q == DIV_LAST) |=> (state_q == ST_OUT), "division did not end in result stage")
  `PN2F_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > ARITH_LAST, "step counter out of range")

endmodule

@@ sv/perlin_noise_2d_fbm_top.sv @@
// top level of the fractal gradient-noise generator
// A request with opcode 0 writes one entry of the 256-entry permutation table and yields
// no result; the table comes out of reset as identity, tracked by one valid bit per entry,
// so there is no clearing pass. A request with opcode 1 evaluates fractal noise at an
// unsigned Q8.FRAC_BITS point and yields one height, for n octaves (n = octave_count
// limited to 1..MAX_OCTAVES): per octave dependent lookups through the single read port of
// the table, then fade, gradient, lerp and weighting steps on one shared registered
// multiplier; after the last octave a bit-per-cycle divider normalizes the sum. The default
// is four octaves. Configuration must be written only while idle; the block itself does not
// enforce this.
module perlin_noise_2d_fbm_top #(
  parameter int MAX_OCTAVES = pn2f_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = pn2f_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [7:0]           table_index_i,
  input  logic [7:0]           table_value_i,
  input  logic [FRAC_BITS+7:0] x_coord_i,
  input  logic [FRAC_BITS+7:0] y_coord_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          height_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  pn2f_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import pn2f_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of lookups, arithmetic, division and hand-off
  pn2f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, multiplier, accumulators and result register
  pn2f_dp #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .height_o      (height_o)
  );

endmodule
